FILE: hw/rtl/mrf_pkg.sv
// mrf_pkg: shared types, constants and the crc byte update for the modbus request framer
// no dependencies; imported by every module of the framer but the checker
package mrf_pkg;

  typedef enum logic [2:0] {
    OP_RD_COILS = 3'd0,
    OP_RD_REGS  = 3'd1,
    OP_WR_COIL  = 3'd2,
    OP_WR_REG   = 3'd3,
    OP_WR_COILS = 3'd4,
    OP_WR_REGS  = 3'd5
  } op_e;

  localparam logic [7:0] FC_RD_COILS = 8'h01;
  localparam logic [7:0] FC_RD_REGS  = 8'h03;
  localparam logic [7:0] FC_WR_COIL  = 8'h05;
  localparam logic [7:0] FC_WR_REG   = 8'h06;
  localparam logic [7:0] FC_WR_COILS = 8'h0F;
  localparam logic [7:0] FC_WR_REGS  = 8'h10;
  localparam logic [7:0] COIL_ON     = 8'hFF;

  localparam logic [15:0] COIL_LIMIT = 16'd1968;
  localparam logic [15:0] REG_LIMIT  = 16'd123;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam int unsigned CMD_BYTES = 7;

  // one queued job for the byte emitter
  typedef struct packed {
    logic                      reject;
    logic                      crc_init;
    logic                      tail;
    logic [2:0]                nbytes;
    logic [CMD_BYTES-1:0][7:0] bytes;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mrf_front.sv
// mrf_front: accepts header and data items, tracks the request phase and builds queue jobs
// depends on mrf_pkg
module mrf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          is_data_i,
  input  logic [2:0]    operation_i,
  input  logic [7:0]    slave_id_i,
  input  logic [15:0]   start_addr_i,
  input  logic [15:0]   quantity_i,
  input  logic [15:0]   data_word_i,
  input  logic          full_i,
  output logic          push_o,
  output mrf_pkg::cmd_t cmd_o
);
  import mrf_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_COILS = 2'd1,
    PH_REGS  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic       accept;
  logic [16:0] qty_p7;
  logic [7:0]  coil_cnt;
  logic [7:0]  left_dec;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign qty_p7     = {1'b0, quantity_i} + 17'd7;
  assign coil_cnt   = qty_p7[10:3];
  assign left_dec   = left_q - 8'd1;

  always_comb begin
    phase_d        = phase_q;
    left_d         = left_q;
    push_o         = 1'b0;
    cmd_o          = '0;
    cmd_o.bytes[0] = slave_id_i;
    cmd_o.bytes[2] = start_addr_i[15:8];
    cmd_o.bytes[3] = start_addr_i[7:0];
    cmd_o.bytes[4] = quantity_i[15:8];
    cmd_o.bytes[5] = quantity_i[7:0];
    cmd_o.crc_init = 1'b1;
    cmd_o.nbytes   = 3'd6;
    cmd_o.tail     = 1'b1;
    if (is_data_i) begin
      cmd_o.crc_init = 1'b0;
      cmd_o.tail     = (left_dec == 8'd0);
      unique case (phase_q)
        PH_COILS: begin
          push_o         = accept;
          cmd_o.nbytes   = 3'd1;
          cmd_o.bytes[0] = data_word_i[7:0];
        end
        PH_REGS: begin
          push_o         = accept;
          cmd_o.nbytes   = 3'd2;
          cmd_o.bytes[0] = data_word_i[15:8];
          cmd_o.bytes[1] = data_word_i[7:0];
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
      if (push_o) begin
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_IDLE;
        end
      end
    end else begin
      push_o = accept;
      unique case (operation_i)
        OP_RD_COILS: cmd_o.bytes[1] = FC_RD_COILS;
        OP_RD_REGS:  cmd_o.bytes[1] = FC_RD_REGS;
        OP_WR_COIL: begin
          cmd_o.bytes[1] = FC_WR_COIL;
          cmd_o.bytes[4] = (quantity_i != 16'd0) ? COIL_ON : 8'h00;
          cmd_o.bytes[5] = 8'h00;
        end
        OP_WR_REG:   cmd_o.bytes[1] = FC_WR_REG;
        OP_WR_COILS: begin
          cmd_o.bytes[1] = FC_WR_COILS;
          cmd_o.bytes[6] = coil_cnt;
          cmd_o.nbytes   = 3'd7;
          cmd_o.tail     = 1'b0;
          cmd_o.reject   = (quantity_i == 16'd0) || (quantity_i > COIL_LIMIT);
        end
        OP_WR_REGS: begin
          cmd_o.bytes[1] = FC_WR_REGS;
          cmd_o.bytes[6] = {quantity_i[6:0], 1'b0};
          cmd_o.nbytes   = 3'd7;
          cmd_o.tail     = 1'b0;
          cmd_o.reject   = (quantity_i == 16'd0) || (quantity_i > REG_LIMIT);
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
      if (push_o) begin
        phase_d = PH_IDLE;
        left_d  = 8'd0;
        if (!cmd_o.reject) begin
          if (operation_i == OP_WR_COILS) begin
            phase_d = PH_COILS;
            left_d  = coil_cnt;
          end else if (operation_i == OP_WR_REGS) begin
            phase_d = PH_REGS;
            left_d  = quantity_i[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: hw/rtl/mrf_queue.sv
// mrf_queue: two-entry job queue between the front and the byte emitter
// depends on mrf_pkg
module mrf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrf_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mrf_pkg::cmd_t cmd_o
);
  import mrf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/mrf_back.sv
// mrf_back: walks each queued job byte by byte, keeps the running crc, drives the output register
// depends on mrf_pkg
module mrf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  mrf_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          frame_end_o,
  output logic          rejected_o
);
  import mrf_pkg::*;

  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;
  logic        out_rej_q, out_rej_d;
  logic        load;
  logic        done;
  logic [15:0] crc_cur;
  logic [15:0] crc_nxt;
  logic [7:0]  byte_nxt;
  logic        end_nxt;
  logic        rej_nxt;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);
  assign crc_cur = (head_i.crc_init && idx_q == 3'd0) ? CRC_INIT : crc_q;

  always_comb begin
    byte_nxt = 8'h00;
    end_nxt  = 1'b0;
    rej_nxt  = 1'b0;
    done     = 1'b0;
    crc_nxt  = crc_cur;
    if (head_i.reject) begin
      end_nxt = 1'b1;
      rej_nxt = 1'b1;
      done    = 1'b1;
      crc_nxt = CRC_INIT;
    end else if (idx_q < head_i.nbytes) begin
      byte_nxt = head_i.bytes[idx_q];
      crc_nxt  = crc_byte(crc_cur, head_i.bytes[idx_q]);
      done     = !head_i.tail && (idx_q == head_i.nbytes - 3'd1);
    end else if (idx_q == head_i.nbytes) begin
      byte_nxt = crc_cur[7:0];
    end else begin
      byte_nxt = crc_cur[15:8];
      end_nxt  = 1'b1;
      done     = 1'b1;
      crc_nxt  = CRC_INIT;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_rej_d   = out_rej_q;
    if (load) begin
      idx_d       = done ? 3'd0 : idx_q + 3'd1;
      crc_d       = crc_nxt;
      out_valid_d = 1'b1;
      out_byte_d  = byte_nxt;
      out_end_d   = end_nxt;
      out_rej_d   = rej_nxt;
    end
  end

  assign pop_o       = load && done;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = out_end_q;
  assign rejected_o  = out_rej_q;

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
    out_rej_q  <= out_rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/modbus_request_framer_top.sv
// modbus_request_framer_top: modbus rtu request framer, front classifier, job queue, byte emitter
// depends on mrf_pkg, mrf_front, mrf_queue, mrf_back
//
// channel | direction | handshake              | payload
// in      | sink      | in_valid_i, in_stall_o | is_data, operation, slave_id, start_addr,
//         |           |                        | quantity, data_word
// out     | source    | out_valid_o, out_stall_i | out_byte, frame_end, rejected
//
// one output byte per cycle from the emitter while not stalled; a read or single write header
// emits 8 bytes, a multiple write header 7, a coil data item 1 (3 with crc), a register item 2 (4 with crc)
// a rejection emits one byte, an ignored item none; items enter every cycle while the queue has room
// the two-entry queue lets the front take new items while the emitter is stalled downstream
// reset clears phase, counts, queue pointers and the output valid; crc restarts at 0xFFFF
module modbus_request_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        is_data_i,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  slave_id_i,
  input  logic [15:0] start_addr_i,
  input  logic [15:0] quantity_i,
  input  logic [15:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        rejected_o
);
  import mrf_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t cmd_in;
  cmd_t cmd_head;

  mrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .is_data_i    (is_data_i),
    .operation_i  (operation_i),
    .slave_id_i   (slave_id_i),
    .start_addr_i (start_addr_i),
    .quantity_i   (quantity_i),
    .data_word_i  (data_word_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  mrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (cmd_head)
  );

  mrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (cmd_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .rejected_o   (rejected_o)
  );

endmodule

FILE: hw/rtl/mrf_checker.sv
// mrf_checker: port-level assertions for the modbus request framer, bound to the top level
// depends on modbus_request_framer_top ports only
module mrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       frame_end_o,
  input logic       rejected_o
);

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(frame_end_o) && $stable(rejected_o))
    else $error("stalled output changed");

  // rejection is a single zero byte that closes the frame
  a_rej_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> frame_end_o && (out_byte_o == 8'h00))
    else $error("malformed rejection");

  // input only backs up while the emitter has a byte on the output
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with idle output");

endmodule

bind modbus_request_framer_top mrf_checker u_mrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .frame_end_o (frame_end_o),
  .rejected_o  (rejected_o)
);

FILE: bench/tb_modbus_request_framer_top.sv
// tb_modbus_request_framer_top: self-checking bench for the modbus rtu request framer
// depends on mrf_pkg and modbus_request_framer_top; predicts every frame byte and the crc,
// drives random idling on the input and random stalls on the output and checks each byte in order
module tb_modbus_request_framer_top;
  import mrf_pkg::*;

  localparam logic [2:0] OP_RSVD_LO = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 145;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COILS,
    PH_REGS
  } phase_e;

  typedef struct packed {
    logic        is_data;
    logic [2:0]  operation;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] word;
  } req_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       rej;
  } frame_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        is_data_i = 1'b0;
  logic [2:0]  operation_i = '0;
  logic [7:0]  slave_id_i = '0;
  logic [15:0] start_addr_i = '0;
  logic [15:0] quantity_i = '0;
  logic [15:0] data_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic        rejected_o;

  req_item_t   pending_items[$];
  frame_byte_t bytes_due[$];

  phase_e      phase_q = PH_IDLE;
  logic [15:0] crc_q = CRC_INIT;
  logic [7:0]  left_q = '0;

  int  mismatches = 0;
  int  in_sent = 0;
  int  drain_at = -1;
  int  cyc = 0;
  int  stuck = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_fired = 1'b0;
  logic quiet;

  modbus_request_framer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .is_data_i   (is_data_i),
    .operation_i (operation_i),
    .slave_id_i  (slave_id_i),
    .start_addr_i(start_addr_i),
    .quantity_i  (quantity_i),
    .data_word_i (data_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .rejected_o  (rejected_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  assign quiet = (cyc >= 300) && (cyc < 1100);

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic fend, input logic rej);
    bytes_due.push_back({b, fend, rej});
  endtask

  task automatic put_crc(input logic [7:0] b);
    crc_q = crc_next(crc_q, b);
    put_byte(b, 1'b0, 1'b0);
  endtask

  task automatic put_tail();
    put_byte(crc_q[7:0], 1'b0, 1'b0);
    put_byte(crc_q[15:8], 1'b1, 1'b0);
    crc_q = CRC_INIT;
    left_q = '0;
    phase_q = PH_IDLE;
  endtask

  task automatic frame_request(input req_item_t it);
    logic [16:0] cnt;
    logic [7:0]  fc;
    if (it.is_data) begin
      case (phase_q)
        PH_COILS: put_crc(it.word[7:0]);
        PH_REGS: begin
          put_crc(it.word[15:8]);
          put_crc(it.word[7:0]);
        end
        default: return;
      endcase
      left_q = left_q - 8'd1;
      if (left_q == 8'd0) begin
        put_tail();
      end
      return;
    end
    if (it.operation == OP_RSVD_LO || it.operation == OP_RSVD_HI) begin
      return;
    end
    if ((it.operation == OP_WR_COILS && (it.qty == '0 || it.qty > COIL_LIMIT)) ||
        (it.operation == OP_WR_REGS && (it.qty == '0 || it.qty > REG_LIMIT))) begin
      phase_q = PH_IDLE;
      crc_q = CRC_INIT;
      left_q = '0;
      put_byte(8'h00, 1'b1, 1'b1);
      return;
    end
    case (it.operation)
      OP_RD_COILS: fc = FC_RD_COILS;
      OP_RD_REGS:  fc = FC_RD_REGS;
      OP_WR_COIL:  fc = FC_WR_COIL;
      OP_WR_REG:   fc = FC_WR_REG;
      OP_WR_COILS: fc = FC_WR_COILS;
      default:     fc = FC_WR_REGS;
    endcase
    crc_q = CRC_INIT;
    put_crc(it.slave);
    put_crc(fc);
    put_crc(it.addr[15:8]);
    put_crc(it.addr[7:0]);
    if (it.operation == OP_WR_COIL) begin
      put_crc((it.qty != '0) ? COIL_ON : 8'h00);
      put_crc(8'h00);
    end else begin
      put_crc(it.qty[15:8]);
      put_crc(it.qty[7:0]);
    end
    case (it.operation)
      OP_WR_COILS: begin
        cnt = (it.qty + 17'd7) >> 3;
        put_crc(cnt[7:0]);
        left_q = cnt[7:0];
        phase_q = PH_COILS;
      end
      OP_WR_REGS: begin
        put_crc({it.qty[6:0], 1'b0});
        left_q = it.qty[7:0];
        phase_q = PH_REGS;
      end
      default: put_tail();
    endcase
  endtask

  task automatic report(input string what, input frame_byte_t want, input frame_byte_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected byte %h end %b rej %b, got byte %h end %b rej %b", what,
               want.data, want.fend, want.rej, got.data, got.fend, got.rej);
    end
  endtask

  task automatic add_header(input logic [2:0] op, input logic [7:0] sl, input logic [15:0] ad,
                            input logic [15:0] q);
    req_item_t it;
    it.is_data = 1'b0;
    it.operation = op;
    it.slave = sl;
    it.addr = ad;
    it.qty = q;
    it.word = 16'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_data(input logic [15:0] w);
    req_item_t it;
    it.is_data = 1'b1;
    it.operation = 3'($urandom);
    it.slave = 8'($urandom);
    it.addr = 16'($urandom);
    it.qty = 16'($urandom);
    it.word = w;
    pending_items.push_back(it);
  endtask

  // input side: acceptance and prediction at the rising edge
  always @(posedge clk_i) begin : in_watch
    in_fired = rst_ni && in_valid_i && !in_stall_o;
    if (in_fired) begin
      frame_request(pending_items[0]);
      void'(pending_items.pop_front());
      in_sent++;
    end
  end

  always @(negedge clk_i) begin : drive_in
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fired) begin
      if (pending_items.size() != 0 && !(in_sent == drain_at && bytes_due.size() != 0) &&
          (quiet || $urandom_range(0, 99) >= 18)) begin
        in_valid_i   <= 1'b1;
        is_data_i    <= pending_items[0].is_data;
        operation_i  <= pending_items[0].operation;
        slave_id_i   <= pending_items[0].slave;
        start_addr_i <= pending_items[0].addr;
        quantity_i   <= pending_items[0].qty;
        data_word_i  <= pending_items[0].word;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: random stalls outside the quiet window, and one long hold once 40 items are in
  always @(negedge clk_i) begin : drive_out
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_sent >= 40) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 18);
    end
  end

  always @(posedge clk_i) begin : out_check
    frame_byte_t got;
    frame_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_byte_o, frame_end_o, rejected_o};
      if (bytes_due.size() == 0) begin
        report("unexpected byte", '0, got);
      end else begin
        want = bytes_due.pop_front();
        if (got !== want) begin
          report("byte mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cyc <= cyc + 1;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    int q;
    int pick;
    int n_dir;
    int part;
    logic [2:0] op;
    bit big_done;

    big_done = 1'b0;

    // directed
    add_header(OP_RD_COILS, 8'h00, 16'h0000, 16'h0000);
    add_header(OP_RD_REGS, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_header(OP_WR_COIL, 8'h11, 16'h0013, 16'h1234);
    add_header(OP_WR_COIL, 8'h11, 16'h0013, 16'h0000);
    add_header(OP_WR_REG, 8'h01, 16'h0001, 16'hA55A);
    add_header(OP_WR_COILS, 8'h02, 16'h0100, COIL_LIMIT + 16'd1);
    add_header(OP_WR_REGS, 8'h03, 16'h0200, REG_LIMIT + 16'd1);
    add_header(OP_WR_COILS, 8'h04, 16'h0300, 16'h0000);
    add_header(OP_WR_REGS, 8'h05, 16'h0400, 16'h0000);
    add_header(OP_RSVD_LO, 8'h06, 16'h0500, 16'h0001);
    add_header(OP_RSVD_HI, 8'h07, 16'h0600, 16'h0001);
    add_data(16'hBEEF);
    add_header(OP_WR_COILS, 8'h21, 16'h0013, 16'd9);
    add_data(16'hFFFF);
    add_data(16'h0000);
    add_header(OP_WR_REGS, 8'h22, 16'h0001, 16'd2);
    add_data(16'h0000);
    add_data(16'hFFFF);
    // requests dropped by a new header, at the largest counts, then one that a reserved header does not drop
    add_header(OP_WR_COILS, 8'h23, 16'h8000, COIL_LIMIT);
    add_data(16'h00A5);
    add_header(OP_WR_REGS, 8'h24, 16'h7FFF, REG_LIMIT);
    add_data(16'h5A5A);
    add_header(OP_WR_COILS, 8'h25, 16'h0020, 16'd16);
    add_data(16'h0F0F);
    add_header(OP_RSVD_LO, 8'h26, 16'h0000, 16'h0000);
    add_data(16'hF0F0);
    n_dir = pending_items.size();
    drain_at = n_dir;

    // random
    while (pending_items.size() < n_dir + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      op = 3'($urandom_range(0, 5));
      if (pick < 70) begin
        case (op)
          OP_WR_COIL: begin
            add_header(op, 8'($urandom), 16'($urandom),
                       $urandom_range(0, 1) ? 16'($urandom) : 16'h0000);
          end
          OP_WR_COILS: begin
            q = $urandom_range(1, 48);
            add_header(op, 8'($urandom), 16'($urandom), 16'(q));
            repeat ((q + 7) / 8) add_data(16'($urandom));
          end
          OP_WR_REGS: begin
            if (!big_done && pending_items.size() > n_dir + 10) begin
              q = REG_LIMIT;
              big_done = 1'b1;
            end else begin
              q = $urandom_range(1, 6);
            end
            add_header(op, 8'($urandom), 16'($urandom), 16'(q));
            repeat (q) add_data(16'($urandom));
          end
          default: add_header(op, 8'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end else if (pick < 85) begin
        if ($urandom_range(0, 1)) begin
          q = $urandom_range(9, 48);
          part = $urandom_range(1, (q + 7) / 8 - 1);
          add_header(OP_WR_COILS, 8'($urandom), 16'($urandom), 16'(q));
        end else begin
          q = $urandom_range(2, 6);
          part = $urandom_range(1, q - 1);
          add_header(OP_WR_REGS, 8'($urandom), 16'($urandom), 16'(q));
        end
        repeat (part) add_data(16'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: add_data(16'($urandom));
          1: add_header(3'($urandom_range(6, 7)), 8'($urandom), 16'($urandom), 16'($urandom));
          2: add_header(OP_WR_COILS, 8'($urandom), 16'($urandom),
                        $urandom_range(0, 1) ? 16'h0000 :
                        16'($urandom_range(COIL_LIMIT + 1, 65535)));
          default: add_header(OP_WR_REGS, 8'($urandom), 16'($urandom),
                              $urandom_range(0, 1) ? 16'h0000 :
                              16'($urandom_range(REG_LIMIT + 1, 65535)));
        endcase
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_items.size() == 0);
    wait (bytes_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bytes_due.size() != 0) begin
      report("bytes never sent, first", bytes_due[0], '0);
      mismatches += bytes_due.size() - 1;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
